[hdl/qte_pkg.sv]
// Package: widths, constants and helper functions for the quaternion to Euler angle pipeline.
package qte_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int QUAT_FRAC_BITS  = 30;

  localparam int QW   = 32;  // input component width
  localparam int ARGW = 34;  // atan2 argument width
  localparam int CW   = 36;  // CORDIC x/y width
  localparam int AW   = 34;  // angle width, Q24 degrees

  localparam int SQRT_ITERS     = 31;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = (SQRT_ITERS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

  localparam int CORDIC_STEPS     = 28;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;

  // front (3) + sqrt + products..radicand (4) + sqrt + cordic (pre + steps) + output
  localparam int LAT = 3 + SQRT_STAGES + 4 + SQRT_STAGES + CORDIC_STAGES + 1 + 1;

  localparam logic [60:0] ONE_Q60 = 61'(1) << 60;
  localparam logic signed [QW-1:0] Q_ONE = QW'(longint'(1) << QUAT_FRAC_BITS);
  localparam int Q_SHIFT = 30 - QUAT_FRAC_BITS;

  localparam int ANG_SHIFT = 24 - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (ANG_SHIFT - 1);
  localparam logic signed [AW-1:0] LIM_180    = AW'(180) << ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] LIM_90     = AW'(90) << ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] ANG_90     = AW'(90) << 24;

  localparam longint DEG_PER_RAD_Q24 = 64'sd961263669;
  localparam longint ATAN_LUT [12] = '{
    64'sd754974720, 64'sd445687602, 64'sd235489088, 64'sd119537938,
    64'sd60000934,  64'sd30029717,  64'sd15018523,  64'sd7509720,
    64'sd3754917,   64'sd1877466,   64'sd938734,    64'sd469367
  };

  typedef struct packed {
    logic                  zero;
    logic signed [AW-1:0]  ang;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
  } cord_t;

  function automatic logic signed [AW-1:0] step_angle(input int i);
    if (i < 12) begin
      return AW'(ATAN_LUT[i]);
    end
    return AW'((DEG_PER_RAD_Q24 + (longint'(1) << (i - 1))) >>> i);
  endfunction

  // saturate to +-1.0 and bring to Q30
  function automatic logic signed [QW-1:0] load_comp(input logic signed [QW-1:0] raw);
    logic signed [QW-1:0] v;
    v = raw;
    if (v > Q_ONE) begin
      v = Q_ONE;
    end
    if (v < -Q_ONE) begin
      v = -Q_ONE;
    end
    return v <<< Q_SHIFT;
  endfunction

  // round half up to the output unit and saturate
  function automatic logic signed [AW-1:0] to_angle(input logic signed [AW-1:0] ang,
                                                    input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] r;
    r = (ang + ROUND_HALF) >>> ANG_SHIFT;
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

[hdl/qte_isqrt.sv]
// Pipelined floor integer square root of a Q60 radicand, two bits per stage.
module qte_isqrt import qte_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [60:0] rad_i,
  output logic [30:0] root_o
);

  logic [60:0] v_q [SQRT_STAGES];
  logic [61:0] r_q [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    logic [60:0] v_in, v_d;
    logic [61:0] r_in, r_d;

    if (j == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[j-1];
      assign r_in = r_q[j-1];
    end

    always_comb begin
      logic [61:0] bit_v;
      logic [61:0] trial;
      bit_v = '0;
      trial = '0;
      v_d   = v_in;
      r_d   = r_in;
      for (int t = 0; t < SQRT_PER_STAGE; t++) begin
        if (SQRT_PER_STAGE * j + t < SQRT_ITERS) begin
          bit_v = 62'(1) << (60 - 2 * (SQRT_PER_STAGE * j + t));
          trial = r_d + bit_v;
          if ({1'b0, v_d} >= trial) begin
            v_d = v_d - trial[60:0];
            r_d = (r_d >> 1) + bit_v;
          end else begin
            r_d = r_d >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[j] <= v_d;
        r_q[j] <= r_d;
      end
    end
  end

  assign root_o = r_q[SQRT_STAGES-1][30:0];

endmodule

[hdl/qte_cordic.sv]
// Pipelined vectoring CORDIC: atan2(y, x) in Q24 degrees.
module qte_cordic import qte_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [ARGW-1:0] y_i,
  input  logic signed [ARGW-1:0] x_i,
  output logic signed [AW-1:0]   ang_o
);

  cord_t pre_d, pre_q;
  cord_t st_q [CORDIC_STAGES];

  // left half-plane: rotate by +-90 degrees first
  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.ang  = '0;
    pre_d.x    = CW'(x_i);
    pre_d.y    = CW'(y_i);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        pre_d.x   = CW'(y_i);
        pre_d.y   = -CW'(x_i);
        pre_d.ang = ANG_90;
      end else begin
        pre_d.x   = -CW'(y_i);
        pre_d.y   = CW'(x_i);
        pre_d.ang = -ANG_90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
    end
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_stage
    cord_t c_in, c_d;

    if (j == 0) begin : g_first
      assign c_in = pre_q;
    end else begin : g_next
      assign c_in = st_q[j-1];
    end

    always_comb begin
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      int i;
      c_d = c_in;
      for (int t = 0; t < CORDIC_PER_STAGE; t++) begin
        i  = CORDIC_PER_STAGE * j + t;
        xs = c_d.x >>> i;
        ys = c_d.y >>> i;
        if (c_d.y > 0) begin
          c_d.x   = c_d.x + ys;
          c_d.y   = c_d.y - xs;
          c_d.ang = c_d.ang + step_angle(i);
        end else begin
          c_d.x   = c_d.x - ys;
          c_d.y   = c_d.y + xs;
          c_d.ang = c_d.ang - step_angle(i);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= c_d;
      end
    end
  end

  assign ang_o = st_q[CORDIC_STAGES-1].zero ? '0 : st_q[CORDIC_STAGES-1].ang;

endmodule

[hdl/quaternion_to_euler_angles.sv]
// Throughput: one item per cycle while the output is not stalled; the two 16-stage
// square roots and the 15-stage CORDICs are fully pipelined, and a stall on the output
// freezes the whole pipeline.
// Reset clears the valid bits and the upside-down setting; data registers are not reset.
// Top level: quaternion to roll/pitch/yaw pipeline with APB setting register.
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [QW-1:0]  quat_b_i,
  input  logic signed [QW-1:0]  quat_c_i,
  input  logic signed [QW-1:0]  quat_d_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [15:0]    roll_angle_o,
  output logic signed [14:0]    pitch_angle_o,
  output logic signed [15:0]    yaw_angle_o
);

  logic upside_q;
  logic en;
  logic [LAT-1:0] vld_q;

  // config register; paddr is ignored, so every address maps to register 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upside_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      upside_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {31'b0, upside_q} | {30'b0, paddr & 2'b00};

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[LAT-1];

  // front: clamp, squares, radicand
  logic signed [QW-1:0] b1_q, c1_q, d1_q;
  logic [60:0]          bb_q, cc_q, dd_q;
  logic signed [QW-1:0] x2_q, y2_q, z2_q, x3_q, y3_q, z3_q;
  logic [60:0]          rad_q;
  logic [61:0]          sum_d;
  logic signed [63:0]   bb_d, cc_d, dd_d;

  assign bb_d  = 64'(b1_q) * 64'(b1_q);
  assign cc_d  = 64'(c1_q) * 64'(c1_q);
  assign dd_d  = 64'(d1_q) * 64'(d1_q);
  assign sum_d = 62'(bb_q) + 62'(cc_q) + 62'(dd_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q  <= load_comp(quat_b_i);
      c1_q  <= load_comp(quat_c_i);
      d1_q  <= load_comp(quat_d_i);
      bb_q  <= bb_d[60:0];
      cc_q  <= cc_d[60:0];
      dd_q  <= dd_d[60:0];
      x2_q  <= c1_q;
      y2_q  <= b1_q;
      z2_q  <= -d1_q;
      rad_q <= (sum_d < 62'(ONE_Q60)) ? ONE_Q60 - sum_d[60:0] : '0;
      x3_q  <= x2_q;
      y3_q  <= y2_q;
      z3_q  <= z2_q;
    end
  end

  logic [30:0] w_root;

  qte_isqrt u_sqrt_w (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (w_root)
  );

  logic signed [QW-1:0] xd_q [SQRT_STAGES];
  logic signed [QW-1:0] yd_q [SQRT_STAGES];
  logic signed [QW-1:0] zd_q [SQRT_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q[0] <= x3_q;
      yd_q[0] <= y3_q;
      zd_q[0] <= z3_q;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        xd_q[k] <= xd_q[k-1];
        yd_q[k] <= yd_q[k-1];
        zd_q[k] <= zd_q[k-1];
      end
    end
  end

  // products of w, x, y, z
  logic signed [QW-1:0] w_s, x_s, y_s, z_s;
  logic signed [63:0]   wx_d, yz_d, xx_d, yy_d, wy_d, xz_d, wz_d, xy_d, zz_d;
  logic signed [61:0]   wx_q, yz_q, xx_q, yy_q, wy_q, xz_q, wz_q, xy_q, zz_q;

  assign w_s  = $signed({1'b0, w_root});
  assign x_s  = xd_q[SQRT_STAGES-1];
  assign y_s  = yd_q[SQRT_STAGES-1];
  assign z_s  = zd_q[SQRT_STAGES-1];
  assign wx_d = 64'(w_s) * 64'(x_s);
  assign yz_d = 64'(y_s) * 64'(z_s);
  assign xx_d = 64'(x_s) * 64'(x_s);
  assign yy_d = 64'(y_s) * 64'(y_s);
  assign wy_d = 64'(w_s) * 64'(y_s);
  assign xz_d = 64'(x_s) * 64'(z_s);
  assign wz_d = 64'(w_s) * 64'(z_s);
  assign xy_d = 64'(x_s) * 64'(y_s);
  assign zz_d = 64'(z_s) * 64'(z_s);

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= wx_d[61:0];
      yz_q <= yz_d[61:0];
      xx_q <= xx_d[61:0];
      yy_q <= yy_d[61:0];
      wy_q <= wy_d[61:0];
      xz_q <= xz_d[61:0];
      wz_q <= wz_d[61:0];
      xy_q <= xy_d[61:0];
      zz_q <= zz_d[61:0];
    end
  end

  // atan2 arguments and the pitch sine
  localparam logic signed [63:0] ONE_S64 = 64'sd1 <<< 60;
  logic signed [63:0]     t0_d, t1_d, t2_d, t2c_d, t3_d, t4_d, s0_d, a0_d, a1_d, a3_d, a4_d;
  logic signed [ARGW-1:0] a0_q, a1_q, a3_q, a4_q, a0b_q, a1b_q, a3b_q, a4b_q;
  logic signed [ARGW-1:0] a0c_q, a1c_q, a3c_q, a4c_q;
  logic signed [QW-1:0]   s_q, sb_q, sc_q;
  logic [60:0]            ss_q, rad2_q;
  logic signed [63:0]     ss_d;

  always_comb begin
    t0_d  = 64'sd2 * (64'(wx_q) + 64'(yz_q));
    t1_d  = ONE_S64 - 64'sd2 * (64'(xx_q) + 64'(yy_q));
    t2_d  = 64'sd2 * (64'(wy_q) - 64'(xz_q));
    t3_d  = 64'sd2 * (64'(wz_q) + 64'(xy_q));
    t4_d  = ONE_S64 - 64'sd2 * (64'(yy_q) + 64'(zz_q));
    t2c_d = t2_d;
    if (t2c_d > ONE_S64) begin
      t2c_d = ONE_S64;
    end
    if (t2c_d < -ONE_S64) begin
      t2c_d = -ONE_S64;
    end
    a0_d = t0_d >>> 30;
    a1_d = t1_d >>> 30;
    a3_d = t3_d >>> 30;
    a4_d = t4_d >>> 30;
    s0_d = t2c_d >>> 30;
  end

  assign ss_d = 64'(s_q) * 64'(s_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q   <= a0_d[ARGW-1:0];
      a1_q   <= a1_d[ARGW-1:0];
      a3_q   <= a3_d[ARGW-1:0];
      a4_q   <= a4_d[ARGW-1:0];
      s_q    <= s0_d[QW-1:0];
      ss_q   <= ss_d[60:0];
      sb_q   <= s_q;
      a0b_q  <= a0_q;
      a1b_q  <= a1_q;
      a3b_q  <= a3_q;
      a4b_q  <= a4_q;
      rad2_q <= ONE_Q60 - ss_q;
      sc_q   <= sb_q;
      a0c_q  <= a0b_q;
      a1c_q  <= a1b_q;
      a3c_q  <= a3b_q;
      a4c_q  <= a4b_q;
    end
  end

  logic [30:0] cs_root;

  qte_isqrt u_sqrt_cs (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad2_q),
    .root_o (cs_root)
  );

  logic signed [QW-1:0]   sd_q  [SQRT_STAGES];
  logic signed [ARGW-1:0] a0d_q [SQRT_STAGES];
  logic signed [ARGW-1:0] a1d_q [SQRT_STAGES];
  logic signed [ARGW-1:0] a3d_q [SQRT_STAGES];
  logic signed [ARGW-1:0] a4d_q [SQRT_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0]  <= sc_q;
      a0d_q[0] <= a0c_q;
      a1d_q[0] <= a1c_q;
      a3d_q[0] <= a3c_q;
      a4d_q[0] <= a4c_q;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sd_q[k]  <= sd_q[k-1];
        a0d_q[k] <= a0d_q[k-1];
        a1d_q[k] <= a1d_q[k-1];
        a3d_q[k] <= a3d_q[k-1];
        a4d_q[k] <= a4d_q[k-1];
      end
    end
  end

  logic signed [AW-1:0] roll_ang, pitch_ang, yaw_ang;

  qte_cordic u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (a0d_q[SQRT_STAGES-1]),
    .x_i   (a1d_q[SQRT_STAGES-1]),
    .ang_o (roll_ang)
  );

  qte_cordic u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (ARGW'(sd_q[SQRT_STAGES-1])),
    .x_i   ($signed({3'b000, cs_root})),
    .ang_o (pitch_ang)
  );

  qte_cordic u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (a3d_q[SQRT_STAGES-1]),
    .x_i   (a4d_q[SQRT_STAGES-1]),
    .ang_o (yaw_ang)
  );

  // output stage
  logic signed [AW-1:0] roll_r, pitch_r, yaw_r, roll_n, pitch_n;

  assign roll_r  = to_angle(roll_ang, LIM_180);
  assign pitch_r = to_angle(pitch_ang, LIM_90);
  assign yaw_r   = to_angle(yaw_ang, LIM_180);
  assign roll_n  = upside_q ? -roll_r : roll_r;
  assign pitch_n = upside_q ? -pitch_r : pitch_r;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_angle_o  <= roll_n[15:0];
      pitch_angle_o <= pitch_n[14:0];
      yaw_angle_o   <= yaw_r[15:0];
    end
  end

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(pitch_angle_o) <= 15'sd11520 &&
                     $signed(pitch_angle_o) >= -15'sd11520))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(roll_angle_o) <= 16'sd23040 &&
                     $signed(roll_angle_o) >= -16'sd23040))
    else $error("roll out of range");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(yaw_angle_o) <= 16'sd23040 &&
                     $signed(yaw_angle_o) >= -16'sd23040))
    else $error("yaw out of range");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

endmodule
